### sv/ligcs_pkg.sv
// Package for the label icon glyph code stream block.
// Holds payload structs, controller/datapath command types and constants.
package ligcs_pkg;

  localparam int unsigned NameMaxDefault = 32;
  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;
  localparam logic [7:0]  ChLt     = 8'h3C;
  localparam logic [7:0]  ChGt     = 8'h3E;
  localparam logic [21:0] IconBase = 22'h00E000;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [21:0] glyph_code;
    logic        code_valid;
    logic        is_icon;
    logic        name_overflow;
    logic        last_of_string;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EMPTY = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_BARE  = 4'b1000
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic       step;       // process accepted byte in text/tag mode
    logic       flush_init; // start unclosed-tag flush (feed '<')
    logic       flush_feed; // feed buffer entry at flush index
    logic       flush_adv;  // advance flush index
    logic       clear;      // return stream state to reset
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_tag;
    logic name_empty;
    logic flush_done;   // flush index reached count
  } sts_t;

  // ASCII lowercase of a byte, widened to the decoder width.
  function automatic logic [20:0] lc_byte(input logic [7:0] b);
    lc_byte = {13'd0, ((b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b)};
  endfunction

endpackage

### sv/ligcs_dp.sv
// Datapath: UTF-8 decoder, FNV-1a hash, name buffer, flush walker.
// Depends on ligcs_pkg.
module ligcs_dp import ligcs_pkg::*; #(
  parameter int unsigned NameMax = NameMaxDefault,
  localparam int unsigned LenW = $clog2(NameMax + 2),
  localparam int unsigned IdxW = $clog2(NameMax)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [7:0]  byte_i,
  input  logic [3:0]  size_i,
  output sts_t        sts_o,
  output logic        code_ok_o,   // decoder completed a code this feed
  output logic [21:0] dec_code_o,
  output logic [21:0] icon_code_o,
  output logic        ovf_o
);

  logic            in_tag_q, in_tag_d;
  logic [20:0]     acc_q, acc_d;
  logic [1:0]      pend_q, pend_d;
  logic [31:0]     hash_q, hash_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] fidx_q, fidx_d;
  logic [7:0]      mem [NameMax];
  logic [7:0]      rd_q;
  logic [31:0]     hx;
  logic [7:0]      fb;
  logic            feed;
  logic [20:0]     cp;
  logic            done;
  logic [LenW-1:0] cnt;
  logic [21:0]     off;

  assign off = {2'd0, size_i, 16'd0} >> 4;
  assign cnt = (len_q > LenW'(NameMax)) ? LenW'(NameMax) : len_q;
  assign ovf_o = len_q > LenW'(NameMax);

  // Select decoder byte: stream byte, '<' of a flush, or buffer read data.
  always_comb begin
    fb   = byte_i;
    feed = 1'b0;
    if (cmd_i.flush_init) begin
      fb = ChLt; feed = 1'b1;
    end else if (cmd_i.flush_feed) begin
      fb = rd_q; feed = 1'b1;
    end else if (cmd_i.step && !in_tag_q && byte_i != ChLt) begin
      feed = 1'b1;
    end
  end

  // Lenient UTF-8 decode step.
  always_comb begin
    acc_d = acc_q;
    pend_d = pend_q;
    done = 1'b0;
    cp = 21'd0;
    if (feed) begin
      if (pend_q == 2'd0) begin
        if (!fb[7]) begin
          done = 1'b1; cp = {13'd0, fb};
        end else if (fb[7:5] == 3'b110) begin
          acc_d = {16'd0, fb[4:0]}; pend_d = 2'd1;
        end else if (fb[7:4] == 4'b1110) begin
          acc_d = {17'd0, fb[3:0]}; pend_d = 2'd2;
        end else begin
          acc_d = {18'd0, fb[2:0]}; pend_d = 2'd3;
        end
      end else begin
        acc_d = {acc_q[14:0], fb[5:0]};
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          done = 1'b1; cp = acc_d; acc_d = 21'd0;
        end
      end
    end
  end

  assign hx = hash_q ^ {11'd0, lc_byte(byte_i)};

  // Tag state, hash and length.
  always_comb begin
    in_tag_d = in_tag_q;
    hash_d = hash_q;
    len_d = len_q;
    fidx_d = fidx_q;
    if (cmd_i.step) begin
      if (!in_tag_q) begin
        if (byte_i == ChLt) begin
          in_tag_d = 1'b1;
          hash_d = FnvBasis; len_d = '0;
        end
      end else if (byte_i != ChGt) begin
        hash_d = hx * FnvPrime;
        if (len_q < LenW'(NameMax)) len_d = len_q + 1'b1;
        else len_d = LenW'(NameMax + 1);
      end
    end
    if (cmd_i.flush_init) fidx_d = '0;
    if (cmd_i.flush_adv) fidx_d = fidx_q + 1'b1;
    if (cmd_i.clear) begin
      in_tag_d = 1'b0; hash_d = FnvBasis; len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tag_q <= 1'b0;
      acc_q <= '0;
      pend_q <= '0;
      hash_q <= FnvBasis;
      len_q <= '0;
      fidx_q <= '0;
    end else begin
      in_tag_q <= in_tag_d;
      hash_q <= hash_d;
      len_q <= len_d;
      fidx_q <= fidx_d;
      // A '<' in text or a clear drops partial sequences.
      if (cmd_i.clear || (cmd_i.step && !in_tag_q && byte_i == ChLt)) begin
        acc_q <= '0; pend_q <= '0;
      end else if (cmd_i.flush_init) begin
        acc_q <= acc_d; pend_q <= pend_d;
      end else begin
        acc_q <= acc_d; pend_q <= pend_d;
      end
    end
  end

  // Name buffer: write on tag byte, read next flush entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && in_tag_q && byte_i != ChGt && len_q < LenW'(NameMax))
      mem[len_q[IdxW-1:0]] <= byte_i;
    rd_q <= mem[fidx_d[IdxW-1:0]];
  end

  assign code_ok_o   = done;
  assign dec_code_o  = {1'b0, cp} + off;
  assign icon_code_o = IconBase + {10'd0, hash_q[11:0]} + off;
  assign sts_o.in_tag = in_tag_q;
  assign sts_o.name_empty = (len_q == '0);
  assign sts_o.flush_done = (fidx_q >= cnt);

endmodule

### sv/ligcs_ctrl.sv
// Controller: sequences byte steps, empty-tag pair, flush walk, output.
// Depends on ligcs_pkg.
module ligcs_ctrl import ligcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  in_item_t    in_data_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  output out_item_t   out_data_o,
  input  logic        out_stall_i,
  output cmd_t        cmd_o,
  input  sts_t        sts_i,
  input  logic        code_ok_i,
  input  logic [21:0] dec_code_i,
  input  logic [21:0] icon_code_i,
  input  logic        ovf_i,
  input  logic [3:0]  size_i
);

  state_e    state_q, state_d;
  logic      ov_q, ov_d;        // output register valid
  out_item_t od_q, od_d;
  out_item_t hd_q, hd_d;        // newest flush code, held until the next one
  logic      eos_q, eos_d;      // end flag of the item in progress
  logic      any_q, any_d;      // flush has started and hd_q holds a code
  logic      acc;
  logic      slot;              // output register free this cycle
  logic [21:0] off;

  assign off  = {2'd0, size_i, 16'd0} >> 4;
  assign slot = !ov_q || !out_stall_i;
  assign in_stall_o = !(state_q == ST_IDLE && slot);
  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    ov_d = ov_q && out_stall_i;
    od_d = od_q;
    hd_d = hd_q;
    eos_d = eos_q;
    any_d = any_q;
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          cmd_o.step = 1'b1;
          any_d = 1'b0;
          eos_d = in_data_i.end_of_string;
          if (sts_i.in_tag && in_data_i.text_byte == ChGt) begin
            ov_d = 1'b1;
            if (sts_i.name_empty) begin
              od_d = '{off + 22'(ChLt), 1'b1, 1'b0, 1'b0, 1'b0};
              state_d = ST_EMPTY;
            end else begin
              od_d = '{icon_code_i, 1'b1, 1'b1, 1'b0, in_data_i.end_of_string};
              cmd_o.clear = 1'b1;
            end
          end else if (code_ok_i) begin
            ov_d = 1'b1;
            od_d = '{dec_code_i, 1'b1, 1'b0, 1'b0, in_data_i.end_of_string};
            if (in_data_i.end_of_string) cmd_o.clear = 1'b1;
          end else if (in_data_i.end_of_string) begin
            if (sts_i.in_tag || in_data_i.text_byte == ChLt) state_d = ST_FLUSH;
            else state_d = ST_BARE;
          end
        end
      end
      ST_EMPTY: begin
        if (slot) begin
          ov_d = 1'b1;
          od_d = '{off + 22'(ChGt), 1'b1, 1'b0, 1'b0, eos_q};
          cmd_o.clear = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        // Hold back the newest code until it is known whether it ends the string.
        if (!any_q) begin
          // '<' always completes a code on an idle decoder.
          cmd_o.flush_init = 1'b1;
          hd_d = '{dec_code_i, 1'b1, 1'b0, ovf_i, 1'b0};
          any_d = 1'b1;
        end else if (sts_i.flush_done) begin
          // Trailing partial dropped; the held code is the last one.
          if (slot) begin
            ov_d = 1'b1;
            od_d = hd_q;
            od_d.last_of_string = 1'b1;
            cmd_o.clear = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (slot) begin
          cmd_o.flush_feed = 1'b1;
          cmd_o.flush_adv = 1'b1;
          if (code_ok_i) begin
            ov_d = 1'b1;
            od_d = hd_q;
            hd_d = '{dec_code_i, 1'b1, 1'b0, ovf_i, 1'b0};
          end
        end
      end
      ST_BARE: begin
        if (slot) begin
          ov_d = 1'b1;
          od_d = '{22'd0, 1'b0, 1'b0, 1'b0, 1'b1};
          cmd_o.clear = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q <= 1'b0;
      eos_q <= 1'b0;
      any_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
      eos_q <= eos_d;
      any_q <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
    hd_q <= hd_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i && state_q == ST_IDLE |=> ov_q) else $error("result lost");
  a_nostall_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> in_stall_o) else $error("input taken while busy");
  a_bare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !od_q.code_valid |-> od_q.last_of_string) else $error("bare marker not last");
  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable(od_q)) else $error("stalled result changed");
endmodule

### sv/label_icon_glyph_code_stream.sv
// Label icon glyph code stream: UTF-8 text and <name> icon tags to glyph codes.
// Top level; joins ligcs_ctrl and ligcs_dp. Depends on ligcs_pkg.
//
// Usage:
//   Input channel carries one string byte per transfer with an end flag on
//   the last byte. Output channel carries glyph codes. Both channels use
//   valid/stall; the receiver drives stall. The user writes size_select with
//   cfg_we_i/cfg_data_i only while the block is idle; the block does not check.
// Throughput:
//   One byte per cycle for text and closed tags while the output is taken.
//   An empty tag <> emits its second code from the ST_EMPTY state. An unclosed
//   tag at end of string walks the name buffer, one entry per cycle while the
//   output is taken, through the single buffer read port.
// Output: a result is registered and appears in the cycle after the byte that
//   completes it. During an unclosed-tag walk each code waits until the next
//   code completes or the walk ends, so the last one can carry the end flag.
// Reset: stream state clears, size_select returns to 0, output empties.
// Stall: the output register holds its result; input stalls until the
//   register can accept the next result and the block is idle.
module label_icon_glyph_code_stream import ligcs_pkg::*; #(
  parameter int unsigned NameMax = NameMaxDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_data_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_stall_i,
  input  logic      cfg_we_i,
  input  logic [3:0] cfg_data_i
);

  cmd_t        cmd;
  sts_t        sts;
  logic        code_ok;
  logic [21:0] dec_code, icon_code;
  logic        ovf;
  logic [3:0]  size_q;

  // Hold the size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= '0;
    else if (cfg_we_i) size_q <= cfg_data_i;
  end

  ligcs_dp #(.NameMax(NameMax)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .byte_i(in_data_i.text_byte), .size_i(size_q),
    .sts_o(sts), .code_ok_o(code_ok), .dec_code_o(dec_code),
    .icon_code_o(icon_code), .ovf_o(ovf)
  );

  ligcs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_data_i, .in_stall_o,
    .out_valid_o, .out_data_o, .out_stall_i, .cmd_o(cmd), .sts_i(sts),
    .code_ok_i(code_ok), .dec_code_i(dec_code), .icon_code_i(icon_code),
    .ovf_i(ovf), .size_i(size_q)
  );

endmodule

### bench/tb.sv
// Testbench for label_icon_glyph_code_stream: directed strings, then random strings.
// Predicts glyph codes in-line and checks each output transfer; needs ligcs_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import ligcs_pkg::*;

  localparam int unsigned NameMax = NameMaxDefault;
  localparam int unsigned Settle  = NameMax + 8;

  typedef struct {
    logic [7:0] text_byte;
    logic       eos;
    logic       typed;
    out_item_t  glyph;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  in_item_t  in_data_i;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;
  logic      out_stall_i;
  logic      cfg_we_i;
  logic [3:0] cfg_data_i;

  // predictor state
  logic [3:0]  glyph_size;
  logic        tag_open;
  logic [20:0] seq_acc;
  logic [1:0]  seq_left;
  logic [31:0] tag_hash;
  logic [7:0]  tag_chars [NameMax];
  int unsigned tag_len;

  out_item_t pending_glyphs [$];
  int        errors;
  int        strings_sent;
  int        bytes_sent;
  int        glyphs_seen;
  int        icons_seen;
  int        overflows_seen;
  int        send_idle;
  int        recv_stall;
  bit        hold_go;
  int        hold_cnt;

  label_icon_glyph_code_stream u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Lenient UTF-8 step; returns 1 when a code point completes.
  function automatic bit utf8_step(input logic [7:0] b, inout logic [20:0] acc,
                                   inout logic [1:0] left, output logic [20:0] cp);
    cp = '0;
    if (left == 2'd0) begin
      if (b < 8'h80) begin
        cp = {13'd0, b};
        return 1'b1;
      end
      if ((b & 8'hE0) == 8'hC0) begin
        acc = {16'd0, b[4:0]};
        left = 2'd1;
      end else if ((b & 8'hF0) == 8'hE0) begin
        acc = {17'd0, b[3:0]};
        left = 2'd2;
      end else begin
        acc = {18'd0, b[2:0]};
        left = 2'd3;
      end
      return 1'b0;
    end
    acc = {acc[14:0], b[5:0]};
    left = left - 2'd1;
    if (left == 2'd0) begin
      cp = acc;
      acc = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t make_glyph(input logic [21:0] code, input logic icon,
                                           input logic ovf);
    out_item_t g;
    g.glyph_code     = code + {6'd0, glyph_size, 12'h000};
    g.code_valid     = 1'b1;
    g.is_icon        = icon;
    g.name_overflow  = ovf;
    g.last_of_string = 1'b0;
    return g;
  endfunction

  task automatic clear_stream();
    tag_open = 1'b0;
    seq_acc  = '0;
    seq_left = '0;
    tag_hash = FnvBasis;
    tag_len  = 0;
  endtask

  // Glyph codes caused by one accepted byte.
  task automatic predict_glyphs(input logic [7:0] b, input logic eos, output out_item_t res [$]);
    logic [20:0] cp;
    logic [20:0] facc;
    logic [1:0]  fleft;
    logic [7:0]  lc;
    logic        ovf;
    int unsigned cnt;
    res = {};
    if (!tag_open) begin
      if (b == ChLt) begin
        clear_stream();
        tag_open = 1'b1;
      end else if (utf8_step(b, seq_acc, seq_left, cp)) begin
        res = {res, make_glyph({1'b0, cp}, 1'b0, 1'b0)};
      end
    end else if (b == ChGt) begin
      if (tag_len == 0) begin
        res = {res, make_glyph({14'd0, ChLt}, 1'b0, 1'b0)};
        res = {res, make_glyph({14'd0, ChGt}, 1'b0, 1'b0)};
      end else begin
        res = {res, make_glyph(IconBase + {10'd0, tag_hash[11:0]}, 1'b1, 1'b0)};
      end
      clear_stream();
    end else begin
      lc = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
      tag_hash = (tag_hash ^ {24'd0, lc}) * FnvPrime;
      if (tag_len < NameMax) begin
        tag_chars[tag_len] = b;
        tag_len++;
      end else begin
        tag_len = NameMax + 1;
      end
    end
    if (eos) begin
      if (tag_open) begin
        ovf   = tag_len > NameMax;
        cnt   = ovf ? NameMax : tag_len;
        facc  = '0;
        fleft = '0;
        if (utf8_step(ChLt, facc, fleft, cp)) res = {res, make_glyph({1'b0, cp}, 1'b0, ovf)};
        for (int i = 0; i < cnt; i++) begin
          if (utf8_step(tag_chars[i], facc, fleft, cp))
            res = {res, make_glyph({1'b0, cp}, 1'b0, ovf)};
        end
      end
      if (res.size() == 0) res = {res, out_item_t'('0)};
      res[res.size() - 1].last_of_string = 1'b1;
      clear_stream();
    end
  endtask

  // Offer one byte; on transfer, queue what it should produce.
  task automatic send_byte(input logic [7:0] b, input logic eos, input bit typed,
                           input out_item_t typed_glyph);
    out_item_t res [$];
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{text_byte: b, end_of_string: eos};
    do @(posedge clk_i); while (in_stall_o);
    predict_glyphs(b, eos, res);
    if (typed) res = {typed_glyph};
    pending_glyphs = {pending_glyphs, res};
    bytes_sent++;
    if (eos) strings_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_string(input logic [7:0] s [$]);
    for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1, 1'b0, '0);
  endtask

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    if ($urandom_range(3) != 0) return $urandom_range(1) ? 8'($urandom_range(8'h41, 8'h5A))
                                                         : 8'($urandom_range(8'h61, 8'h7A));
    c = 8'($urandom_range(255));
    return (c == ChGt) ? 8'h3F : c;
  endfunction

  // Mostly well-formed text and tags, with some noise and unclosed tags.
  task automatic make_string(output logic [7:0] s [$]);
    int nseg;
    int nlen;
    s = {};
    nseg = $urandom_range(1, 4);
    for (int k = 0; k < nseg; k++) begin
      case ($urandom_range(9))
        0, 1, 2: s = {s, 8'($urandom_range(127))};
        3: s = {s, 8'(8'hC0 | $urandom_range(31)), 8'(8'h80 | $urandom_range(63))};
        4: s = {s, 8'(8'hE0 | $urandom_range(15)), 8'(8'h80 | $urandom_range(63)),
                8'(8'h80 | $urandom_range(63))};
        5: s = {s, 8'(8'hF0 | $urandom_range(7)), 8'(8'h80 | $urandom_range(63)),
                8'(8'h80 | $urandom_range(63)), 8'(8'h80 | $urandom_range(63))};
        6, 7: begin
          s = {s, ChLt};
          nlen = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
          repeat (nlen) s = {s, name_char()};
          s = {s, ChGt};
        end
        8: s = {s, ChLt, ChGt};
        default: s = {s, 8'($urandom_range(255))};
      endcase
    end
    if ($urandom_range(3) == 0) begin
      s = {s, ChLt};
      nlen = ($urandom_range(4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      repeat (nlen) s = {s, name_char()};
    end
  endtask

  // Write size_select once the block has drained.
  task automatic write_size(input logic [3:0] v);
    wait (pending_glyphs.size() == 0);
    repeat (Settle) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    glyph_size = v;
  endtask

  // Receiver: random stall, with one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_go && hold_cnt < 300) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= hold_cnt + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall);
    end
  end

  // Check each output transfer against the oldest expected glyph.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_glyphs.size() == 0) begin
        $error("unexpected result: code %h", out_data_o.glyph_code);
        errors++;
      end else begin
        want = pending_glyphs.pop_front();
        glyphs_seen++;
        if (want.is_icon) icons_seen++;
        if (want.name_overflow) overflows_seen++;
        if (out_data_o.glyph_code !== want.glyph_code) begin
          $error("glyph_code: expected %h actual %h", want.glyph_code, out_data_o.glyph_code);
          errors++;
        end
        if (out_data_o.code_valid !== want.code_valid) begin
          $error("code_valid: expected %b actual %b", want.code_valid, out_data_o.code_valid);
          errors++;
        end
        if (out_data_o.is_icon !== want.is_icon) begin
          $error("is_icon: expected %b actual %b", want.is_icon, out_data_o.is_icon);
          errors++;
        end
        if (out_data_o.name_overflow !== want.name_overflow) begin
          $error("name_overflow: expected %b actual %b", want.name_overflow,
                 out_data_o.name_overflow);
          errors++;
        end
        if (out_data_o.last_of_string !== want.last_of_string) begin
          $error("last_of_string: expected %b actual %b", want.last_of_string,
                 out_data_o.last_of_string);
          errors++;
        end
      end
    end
  end

  // Hard stop for a hung run.
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    stim_row_t   rows [$];
    logic [7:0]  s [$];
    int          idle_tab [4];
    int          stall_tab [4];
    logic [3:0]  size_tab [4];
    int          target;
    rows = '{
      // single bytes: extremes and a dropped lead byte
      '{8'h41, 1'b1, 1'b1, '{22'h41, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{8'h00, 1'b1, 1'b1, '{22'h00, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{8'h7F, 1'b1, 1'b1, '{22'h7F, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{8'hC3, 1'b1, 1'b1, '{22'h00, 1'b0, 1'b0, 1'b0, 1'b1}},
      // two, three and four byte sequences
      '{8'hC3, 1'b0, 1'b0, '0}, '{8'hA9, 1'b1, 1'b0, '0},
      '{8'hE2, 1'b0, 1'b0, '0}, '{8'h82, 1'b0, 1'b0, '0}, '{8'hAC, 1'b1, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hBF, 1'b0, 1'b0, '0}, '{8'hBF, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b1, 1'b0, '0},
      // stray continuation byte takes the four byte path, cut by end
      '{8'h80, 1'b0, 1'b0, '0}, '{8'h80, 1'b1, 1'b1, '{22'h00, 1'b0, 1'b0, 1'b0, 1'b1}},
      // empty tag
      '{8'h3C, 1'b0, 1'b0, '0}, '{8'h3E, 1'b1, 1'b0, '0},
      // icon tag with mixed case
      '{8'h3C, 1'b0, 1'b0, '0}, '{8'h53, 1'b0, 1'b0, '0}, '{8'h74, 1'b0, 1'b0, '0},
      '{8'h3E, 1'b1, 1'b0, '0},
      // unclosed tag flushed as text, '<' inside the name
      '{8'h3C, 1'b0, 1'b0, '0}, '{8'h3C, 1'b0, 1'b0, '0}, '{8'hC3, 1'b0, 1'b0, '0},
      '{8'hA9, 1'b1, 1'b0, '0}
    };
    idle_tab  = '{0, 87, 0, 23};
    stall_tab = '{0, 0, 87, 23};
    size_tab  = '{4'hF, 4'h0, 4'($urandom_range(1, 14)), 4'hF};
    errors = 0; strings_sent = 0; bytes_sent = 0;
    glyphs_seen = 0; icons_seen = 0; overflows_seen = 0;
    send_idle = 0; recv_stall = 0; hold_go = 1'b0; hold_cnt = 0;
    glyph_size = '0;
    clear_stream();
    rst_ni = 1'b0;
    in_valid_i = 1'b0; in_data_i = '0; out_stall_i = 1'b0;
    cfg_we_i = 1'b0; cfg_data_i = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed strings at reset size
    foreach (rows[i]) send_byte(rows[i].text_byte, rows[i].eos, rows[i].typed, rows[i].glyph);

    // random strings across idle/stall phases and sizes
    for (int p = 0; p < 4; p++) begin
      in_valid_i <= 1'b0;
      write_size(size_tab[p]);
      send_idle  = idle_tab[p];
      recv_stall = stall_tab[p];
      if (p == 0) hold_go = 1'b1;
      target = bytes_sent + 100;
      while (bytes_sent < target) begin
        if ((p == 1 && bytes_sent + 50 >= target && bytes_sent + 40 < target)
            || $urandom_range(19) == 0) begin
          in_valid_i <= 1'b0;
          wait (pending_glyphs.size() == 0);
          @(negedge clk_i);
        end
        make_string(s);
        send_string(s);
      end
    end
    in_valid_i <= 1'b0;
    recv_stall = 0;

    wait (pending_glyphs.size() == 0);
    repeat (Settle) @(posedge clk_i);
    $display("Covered %0d strings, %0d bytes, %0d results checked", strings_sent, bytes_sent,
             glyphs_seen);
    $display("  of which %0d icon codes and %0d overflowed flush codes", icons_seen,
             overflows_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
sv/ligcs_pkg.sv
sv/ligcs_dp.sv
sv/ligcs_ctrl.sv
sv/label_icon_glyph_code_stream.sv
bench/tb.sv
